>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the consensus block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define MCC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication after a fixed number of cycles.
`define MCC_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`else

`define MCC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define MCC_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg)

`endif

`endif

>>> hw/rtl/mcc_pkg.sv
// Types and constants of the alignment column consensus block.
`default_nettype none

package mcc_pkg;

   // Field widths
   localparam int BASE_W    = 2;
   localparam int FRAC_W    = 16;
   localparam int WEIGHT_W  = 17;
   localparam int SUM_W     = 25;
   localparam int CNT_W     = 9;
   localparam int COL_W     = 10;
   localparam int SPAN_W    = 11;
   localparam int NUM_BASES = 4;

   // Derived datapath widths
   localparam int TOT_W     = SUM_W + 2;            // sum of four base weights
   localparam int SUPPORT_W = FRAC_W + 1;           // quotient never exceeds 1.0
   localparam int DIVD_W    = SUM_W + FRAC_W + 1;   // scaled weight plus rounding

   // Limits
   localparam int MAX_ROWS    = 256;
   localparam int MAX_COLUMNS = 1024;
   localparam logic [CNT_W-1:0]  ROW_LIMIT = CNT_W'(MAX_ROWS);
   localparam logic [SPAN_W-1:0] COL_LIMIT = SPAN_W'(MAX_COLUMNS);
   localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};

   // Nucleotide codes
   typedef enum logic [BASE_W-1:0] {
      BASE_A = 2'd0,
      BASE_C = 2'd1,
      BASE_G = 2'd2,
      BASE_T = 2'd3
   } base_type;

   // One row of a column
   typedef struct packed {
      logic [BASE_W-1:0]   base;
      logic [WEIGHT_W-1:0] weight;
      logic                first_row;
      logic                last_row;
      logic [COL_W-1:0]    column;
      logic [SPAN_W-1:0]   span_begin;
      logic [SPAN_W-1:0]   span_end;
   } req_type;

   // Per-column result
   typedef struct packed {
      logic [BASE_W-1:0]    consensus_base;
      logic [SUPPORT_W-1:0] support;
      logic [CNT_W-1:0]     coverage;
      logic [SUM_W-1:0]     subject_base_weight;
      logic [CNT_W-1:0]     subject_base_count;
      logic                 subject_valid;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accum;     // add the accepted row
      logic reduce;    // snapshot pair sums and maxima, clear accumulators
      logic combine;   // total weight and consensus
      logic load;      // prepare the divider
      logic step;      // one quotient bit
      logic emit;      // load the result register
   } ctrl_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/mcc_datapath.sv
// Datapath: per-base accumulators, column reduction, restoring divider, result register.
`default_nettype none
`include "assert_macros.svh"

module mcc_datapath import mcc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_type      req_data,
   input  wire ctrl_cmd_type cmd,
   output rsp_type           rsp_data
);

   // Accumulators
   logic [SUM_W-1:0]  wsum_ff [NUM_BASES];
   logic [SUM_W-1:0]  wsum_in [NUM_BASES];
   logic [CNT_W-1:0]  cnt_ff  [NUM_BASES];
   logic [CNT_W-1:0]  cnt_in  [NUM_BASES];
   logic [CNT_W-1:0]  row_total_ff, row_total_in;
   logic [BASE_W-1:0] subj_base_ff, subj_base_in;

   // Span of the latest row
   logic [COL_W-1:0]  col_ff;
   logic [SPAN_W-1:0] span_begin_ff, span_end_ff;

   // Reduction stage
   logic [SUM_W:0]    s01_ff, s01_in, s23_ff, s23_in;
   logic [SUM_W-1:0]  m01_w_ff, m01_w_in, m23_w_ff, m23_w_in;
   base_type          m01_i_ff, m01_i_in, m23_i_ff, m23_i_in;
   logic [CNT_W-1:0]  cov_ff, cov_in;
   logic [SUM_W-1:0]  subj_w_ff, subj_w_in;
   logic [CNT_W-1:0]  subj_c_ff, subj_c_in;
   logic              subj_v_ff, subj_v_in;

   // Combine stage
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [SUM_W-1:0]  cons_w_ff, cons_w_in;
   base_type          cons_i_ff, cons_i_in;

   // Divider
   logic [TOT_W-1:0]     rem_ff, rem_in;
   logic [SUPPORT_W-1:0] quo_ff, quo_in;
   logic                 zero_ff, zero_in;

   rsp_type rsp_ff, rsp_in;

   // Row accumulation scratch
   logic [CNT_W-1:0]  row_base;
   logic [SUM_W-1:0]  cur_sum;
   logic [CNT_W-1:0]  cur_cnt;
   logic [SUM_W:0]    add_sum;
   logic              in_span;
   logic [DIVD_W-1:0] dividend;
   logic [TOT_W:0]    trial;
   logic              trial_ge;
   logic [CNT_W+1:0]  cnt_sum;

   // Accumulate rows; clear once a column is taken for reduction
   always_comb begin
      for (int k = 0; k < NUM_BASES; k++) begin
         wsum_in[k] = wsum_ff[k];
         cnt_in[k]  = cnt_ff[k];
      end
      row_total_in = row_total_ff;
      subj_base_in = subj_base_ff;

      row_base = req_data.first_row ? '0 : row_total_ff;
      cur_sum  = req_data.first_row ? '0 : wsum_ff[req_data.base];
      cur_cnt  = req_data.first_row ? '0 : cnt_ff[req_data.base];
      add_sum  = {1'b0, cur_sum} + (SUM_W+1)'(req_data.weight);

      if (cmd.reduce) begin
         for (int k = 0; k < NUM_BASES; k++) begin
            wsum_in[k] = '0;
            cnt_in[k]  = '0;
         end
         row_total_in = '0;
      end else if (cmd.accum) begin
         if (req_data.first_row) begin
            for (int k = 0; k < NUM_BASES; k++) begin
               wsum_in[k] = '0;
               cnt_in[k]  = '0;
            end
            row_total_in = '0;
            subj_base_in = req_data.base;
         end
         if (row_base < ROW_LIMIT) begin
            wsum_in[req_data.base] = add_sum[SUM_W] ? SUM_MAX : add_sum[SUM_W-1:0];
            cnt_in[req_data.base]  = cur_cnt + CNT_W'(1);
            row_total_in           = row_base + CNT_W'(1);
         end
      end
   end

   // Reduction: pair sums, pair maxima (ties keep the earlier base), subject fields
   always_comb begin
      in_span = (span_begin_ff <= SPAN_W'(col_ff)) && (SPAN_W'(col_ff) < span_end_ff)
             && (SPAN_W'(col_ff) < COL_LIMIT);
      s01_in   = (SUM_W+1)'(wsum_ff[0]) + (SUM_W+1)'(wsum_ff[1]);
      s23_in   = (SUM_W+1)'(wsum_ff[2]) + (SUM_W+1)'(wsum_ff[3]);
      m01_w_in = (wsum_ff[1] > wsum_ff[0]) ? wsum_ff[1] : wsum_ff[0];
      m01_i_in = (wsum_ff[1] > wsum_ff[0]) ? BASE_C : BASE_A;
      m23_w_in = (wsum_ff[3] > wsum_ff[2]) ? wsum_ff[3] : wsum_ff[2];
      m23_i_in = (wsum_ff[3] > wsum_ff[2]) ? BASE_T : BASE_G;
      cov_in    = row_total_ff;
      subj_w_in = in_span ? wsum_ff[subj_base_ff] : '0;
      subj_c_in = in_span ? cnt_ff[subj_base_ff] : '0;
      subj_v_in = in_span;
   end

   // Combine: total weight and overall maximum
   always_comb begin
      total_in  = TOT_W'(s01_ff) + TOT_W'(s23_ff);
      cons_w_in = (m23_w_ff > m01_w_ff) ? m23_w_ff : m01_w_ff;
      cons_i_in = (m23_w_ff > m01_w_ff) ? m23_i_ff : m01_i_ff;
   end

   // Divider: load scaled weight plus half the total, then one quotient bit a step
   always_comb begin
      dividend = {cons_w_ff, {FRAC_W{1'b0}}} + DIVD_W'(total_ff >> 1);
      trial    = {rem_ff, quo_ff[SUPPORT_W-1]};
      trial_ge = (trial >= {1'b0, total_ff});
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      zero_in  = zero_ff;
      if (cmd.load) begin
         rem_in  = TOT_W'(dividend[DIVD_W-1:SUPPORT_W]);
         quo_in  = dividend[SUPPORT_W-1:0];
         zero_in = (total_ff == '0);
      end else if (cmd.step) begin
         rem_in = trial_ge ? TOT_W'(trial - {1'b0, total_ff}) : TOT_W'(trial);
         quo_in = {quo_ff[SUPPORT_W-2:0], trial_ge};
      end
   end

   // Result word
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         rsp_in.consensus_base      = cons_i_ff;
         rsp_in.support             = zero_ff ? '0 : quo_ff;
         rsp_in.coverage            = cov_ff;
         rsp_in.subject_base_weight = subj_w_ff;
         rsp_in.subject_base_count  = subj_c_ff;
         rsp_in.subject_valid       = subj_v_ff;
      end
   end

   assign rsp_data = rsp_ff;

   // Accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_BASES; k++) begin
            wsum_ff[k] <= '0;
            cnt_ff[k]  <= '0;
         end
         row_total_ff <= '0;
         subj_base_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_BASES; k++) begin
            wsum_ff[k] <= wsum_in[k];
            cnt_ff[k]  <= cnt_in[k];
         end
         row_total_ff <= row_total_in;
         subj_base_ff <= subj_base_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accum) begin
         col_ff        <= req_data.column;
         span_begin_ff <= req_data.span_begin;
         span_end_ff   <= req_data.span_end;
      end
      if (cmd.reduce) begin
         s01_ff    <= s01_in;
         s23_ff    <= s23_in;
         m01_w_ff  <= m01_w_in;
         m01_i_ff  <= m01_i_in;
         m23_w_ff  <= m23_w_in;
         m23_i_ff  <= m23_i_in;
         cov_ff    <= cov_in;
         subj_w_ff <= subj_w_in;
         subj_c_ff <= subj_c_in;
         subj_v_ff <= subj_v_in;
      end
      if (cmd.combine) begin
         total_ff  <= total_in;
         cons_w_ff <= cons_w_in;
         cons_i_ff <= cons_i_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
      rsp_ff  <= rsp_in;
   end

   // Checks
   assign cnt_sum = (CNT_W+2)'(cnt_ff[0]) + (CNT_W+2)'(cnt_ff[1])
                  + (CNT_W+2)'(cnt_ff[2]) + (CNT_W+2)'(cnt_ff[3]);

   `MCC_ASSERT_IMP(a_cov_matches_counts, clock, reset, cmd.reduce, (CNT_W+2)'(row_total_ff) == cnt_sum, "coverage differs from per-base counts")
   `MCC_ASSERT_IMP(a_cons_le_total, clock, reset, cmd.load, TOT_W'(cons_w_ff) <= total_ff, "consensus weight above total")
   `MCC_ASSERT_IMP(a_rem_below_div, clock, reset, cmd.step && (total_ff != '0), rem_ff < total_ff, "divider remainder not below divisor")

endmodule

`default_nettype wire

>>> hw/rtl/mcc_ctrl.sv
// Controller: row handshake, column finishing sequence, result valid.
`default_nettype none
`include "assert_macros.svh"

module mcc_ctrl import mcc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   input  wire logic   req_last_row,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output ctrl_cmd_type cmd
);

   localparam int STEP_W = $clog2(SUPPORT_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUPPORT_W - 1);
   localparam int FINISH_CYCLES = SUPPORT_W + 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_COMBINE,
      ST_LOAD,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_take;
   logic              slot_free;

   // Commands
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      req_take    = req_valid && req_ready;
      slot_free   = !rsp_valid_ff || rsp_ready;
      cmd.accum   = req_take;
      cmd.reduce  = (state_ff == ST_REDUCE);
      cmd.combine = (state_ff == ST_COMBINE);
      cmd.load    = (state_ff == ST_LOAD);
      cmd.step    = (state_ff == ST_DIVIDE);
      cmd.emit    = (state_ff == ST_DONE) && slot_free;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_take && req_last_row) state_in = ST_REDUCE;
         ST_REDUCE:  state_in = ST_COMBINE;
         ST_COMBINE: state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DONE:    if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Checks
   `MCC_ASSERT_DELAY(a_finish_latency, clock, reset, req_take && req_last_row, FINISH_CYCLES, state_ff == ST_DONE, "column finish took the wrong number of cycles")
   `MCC_ASSERT_IMP(a_step_parked, clock, reset, state_ff != ST_DIVIDE, step_ff == '0, "step counter left running outside division")
   `MCC_ASSERT_IMP(a_valid_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result raised outside the done state")

endmodule

`default_nettype wire

>>> hw/rtl/msa_column_consensus.sv
// Top level: weighted majority consensus of one alignment column.
//
//   channel   direction  handshake             word
//   req_      in         req_valid/req_ready   req_type, one alignment row
//   rsp_      out        rsp_valid/rsp_ready   rsp_type, one column result
//
// A row without the last-row mark only updates the accumulators and leaves req_ready high.
// A last row is followed by reduce, combine, divider load, 17 restoring-divider steps for
// the support quotient and the write of the result register.
// Reset clears the accumulators and the controller; there is no clearing pass.
// A result waiting on rsp_ready stays in the output register while further rows
// are taken; the next column's result then holds in the done state, with
// req_ready low, until that register is free.
`default_nettype none

module msa_column_consensus import mcc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   ctrl_cmd_type cmd;

   mcc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_row (req_data.last_row),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd)
   );

   mcc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
